@@ sv/position_pid_clamped_integrator_macros.svh @@
// ----------------------------------------------------------------------------
// position_pid_clamped_integrator_macros
// Assertion macros used by the checker file of the PID block.
// ----------------------------------------------------------------------------
`ifndef POSITION_PID_CLAMPED_INTEGRATOR_MACROS_SVH
`define POSITION_PID_CLAMPED_INTEGRATOR_MACROS_SVH

// Plain clocked assertion, disabled in reset
`define PIDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Assertion that also runs while reset is asserted
`define PIDC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ sv/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Types, constants and saturation helpers of the PID position loop.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

    localparam int DATA_W = 32;
    localparam int STEP_W = 31;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 64;
    localparam int FRAC_W = 16;
    localparam int FL_W   = PROD_W - FRAC_W;
    localparam int ACC_W  = 50;
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_STEP_TIME  = 3'd3;
    localparam logic [2:0] REG_LIMIT_LOW  = 3'd4;
    localparam logic [2:0] REG_LIMIT_HIGH = 3'd5;

    localparam logic [DATA_W-1:0] RST_PROP_GAIN  = 32'sd9830;
    localparam logic [DATA_W-1:0] RST_INTEG_GAIN = 32'sd393;
    localparam logic [DATA_W-1:0] RST_DERIV_GAIN = 32'sd4391;
    localparam logic [STEP_W-1:0] RST_STEP_TIME  = 31'd164;
    localparam logic [DATA_W-1:0] RST_LIMIT_LOW  = -32'sd1638400;
    localparam logic [DATA_W-1:0] RST_LIMIT_HIGH = 32'sd1638400;

    typedef struct packed {
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integ_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic        [STEP_W-1:0] step_time;
        logic signed [DATA_W-1:0] limit_low;
        logic signed [DATA_W-1:0] limit_high;
    } cfg_t;

    // Saturate a floored product to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [FL_W-1:0] x);
        logic signed [FL_W-1:0] max_v;
        logic signed [FL_W-1:0] min_v;
        max_v = {{(FL_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        min_v = {{(FL_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (x > max_v)
            sat32 = max_v[DATA_W-1:0];
        else if (x < min_v)
            sat32 = min_v[DATA_W-1:0];
        else
            sat32 = x[DATA_W-1:0];
    endfunction

    // High limit first, then low limit: crossed limits give the low limit
    function automatic logic signed [ACC_W-1:0] clamp_lim(
        input logic signed [ACC_W-1:0]  x,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [ACC_W-1:0] lo_x;
        logic signed [ACC_W-1:0] hi_x;
        logic signed [ACC_W-1:0] y;
        lo_x = {{(ACC_W-DATA_W){lo[DATA_W-1]}}, lo};
        hi_x = {{(ACC_W-DATA_W){hi[DATA_W-1]}}, hi};
        y = x;
        if (y > hi_x)
            y = hi_x;
        if (y < lo_x)
            y = lo_x;
        clamp_lim = y;
    endfunction

endpackage

`default_nettype wire

@@ sv/position_pid_clamped_integrator.sv @@
// Sequence: a control step item runs through S_MP, S_MI, S_SAT, S_MT, S_MD,
// S_AD and S_OUT, using the single 33x33 multiplier four times per step; a
// clear item goes straight to S_OUT. Both wait in S_OUT while the output is
// stalled, and in_ready is low during the sequence.
// Reset: integral cleared to zero, registers take their default values.
// ----------------------------------------------------------------------------
// position_pid_clamped_integrator
// Q16.16 PID position loop with clamped integral over one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module position_pid_clamped_integrator
    import pidc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     action,
    input  wire logic signed [DATA_W-1:0] target,
    input  wire logic signed [DATA_W-1:0] measured_pos,
    input  wire logic signed [DATA_W-1:0] measured_vel,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      drive,
    output logic signed [DATA_W-1:0]      integ_value,
    output logic signed [DATA_W-1:0]      error_value
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MP   = 3'd1;
    localparam logic [2:0] S_MI   = 3'd2;
    localparam logic [2:0] S_SAT  = 3'd3;
    localparam logic [2:0] S_MT   = 3'd4;
    localparam logic [2:0] S_MD   = 3'd5;
    localparam logic [2:0] S_AD   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    cfg_t cfg;

    logic [2:0]               state_reg, state_next;
    logic                     clear_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [MUL_W-1:0]  nvel_reg;
    logic signed [DATA_W-1:0] ipart_reg;
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] drive_reg, integ_out_reg, err_out_reg;

    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [FL_W-1:0]   prod_fl;
    logic signed [ACC_W-1:0]  prod_x;
    logic signed [MUL_W-1:0]  diff;
    logic signed [DATA_W-1:0] err_sat;
    logic signed [ACC_W-1:0]  integ_sum;
    logic signed [ACC_W-1:0]  integ_clamp;
    logic signed [ACC_W-1:0]  drive_sum;
    logic signed [ACC_W-1:0]  drive_clamp;
    logic                     in_xfer;
    logic                     out_free;

    pidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidc_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // error with saturation to 32 bits
    assign diff = {target[DATA_W-1], target} - {measured_pos[DATA_W-1], measured_pos};
    always_comb
    begin
        if (diff[MUL_W-1] != diff[MUL_W-2])
            err_sat = diff[MUL_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            err_sat = diff[DATA_W-1:0];
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MP:
            begin
                op_a = {cfg.prop_gain[DATA_W-1], cfg.prop_gain};
                op_b = {err_reg[DATA_W-1], err_reg};
            end
            S_MI:
            begin
                op_a = {cfg.integ_gain[DATA_W-1], cfg.integ_gain};
                op_b = {err_reg[DATA_W-1], err_reg};
            end
            S_MT:
            begin
                op_a = {ipart_reg[DATA_W-1], ipart_reg};
                op_b = {{(MUL_W-STEP_W){1'b0}}, cfg.step_time};
            end
            S_MD:
            begin
                op_a = {cfg.deriv_gain[DATA_W-1], cfg.deriv_gain};
                op_b = nvel_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_fl     = prod[PROD_W-1:FRAC_W];
    assign prod_x      = {{(ACC_W-FL_W){prod_fl[FL_W-1]}}, prod_fl};
    assign integ_sum   = {{(ACC_W-DATA_W){integ_reg[DATA_W-1]}}, integ_reg} + prod_x;
    assign integ_clamp = clamp_lim(integ_sum, cfg.limit_low, cfg.limit_high);
    assign drive_sum   = acc_reg + {{(ACC_W-DATA_W){integ_reg[DATA_W-1]}}, integ_reg};
    assign drive_clamp = clamp_lim(drive_sum, cfg.limit_low, cfg.limit_high);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = action ? S_OUT : S_MP;
            end
            S_MP:  state_next = S_MI;
            S_MI:  state_next = S_SAT;
            S_SAT: state_next = S_MT;
            S_MT:  state_next = S_MD;
            S_MD:  state_next = S_AD;
            S_AD:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer && action)
                integ_reg <= '0;
            else if (state_reg == S_MD)
                integ_reg <= integ_clamp[DATA_W-1:0];
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            clear_reg <= action;
            err_reg   <= action ? '0 : err_sat;
            nvel_reg  <= -{measured_vel[DATA_W-1], measured_vel};
        end
        case (state_reg)
            S_MI:    acc_reg   <= prod_x;
            S_SAT:   ipart_reg <= sat32(prod_fl);
            S_AD:    acc_reg   <= acc_reg + prod_x;
            default: acc_reg   <= acc_reg;
        endcase
        if (state_reg == S_OUT && out_free)
        begin
            drive_reg     <= clear_reg ? '0 : drive_clamp[DATA_W-1:0];
            integ_out_reg <= integ_reg;
            err_out_reg   <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;
    assign integ_value = integ_out_reg;
    assign error_value = err_out_reg;

endmodule

`default_nettype wire

@@ sv/pidc_mul.sv @@
// ----------------------------------------------------------------------------
// pidc_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_mul
    import pidc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [MUL_W-1:0]  op_a,
    input  wire logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [2*MUL_W-1:0] full;
    logic signed [PROD_W-1:0]  prod_reg;

    assign full = op_a * op_b;

    // operands stay within 2^31 in magnitude, so 64 bits hold the product
    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ sv/pidc_regs.sv @@
// ----------------------------------------------------------------------------
// pidc_regs
// APB configuration registers: gains, step time and output limits.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_regs
    import pidc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain  <= RST_PROP_GAIN;
            cfg_reg.integ_gain <= RST_INTEG_GAIN;
            cfg_reg.deriv_gain <= RST_DERIV_GAIN;
            cfg_reg.step_time  <= RST_STEP_TIME;
            cfg_reg.limit_low  <= RST_LIMIT_LOW;
            cfg_reg.limit_high <= RST_LIMIT_HIGH;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= pwdata;
                REG_INTEG_GAIN: cfg_reg.integ_gain <= pwdata;
                REG_DERIV_GAIN: cfg_reg.deriv_gain <= pwdata;
                REG_STEP_TIME:  cfg_reg.step_time  <= pwdata[STEP_W-1:0];
                REG_LIMIT_LOW:  cfg_reg.limit_low  <= pwdata;
                REG_LIMIT_HIGH: cfg_reg.limit_high <= pwdata;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PROP_GAIN:  prdata = cfg_reg.prop_gain;
            REG_INTEG_GAIN: prdata = cfg_reg.integ_gain;
            REG_DERIV_GAIN: prdata = cfg_reg.deriv_gain;
            REG_STEP_TIME:  prdata = {1'b0, cfg_reg.step_time};
            REG_LIMIT_LOW:  prdata = cfg_reg.limit_low;
            REG_LIMIT_HIGH: prdata = cfg_reg.limit_high;
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/pidc_chk.sv @@
// ----------------------------------------------------------------------------
// pidc_chk
// Port-level checks of the PID block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "position_pid_clamped_integrator_macros.svh"

module pidc_chk
    import pidc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DATA_W-1:0] drive,
    input wire logic [DATA_W-1:0] integ_value,
    input wire logic [DATA_W-1:0] error_value
);

    // the sequencer holds off new work right after a transfer
    `PIDC_ASSERT(a_busy_after_xfer, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    // a result appears only at the end of a sequence
    `PIDC_ASSERT(a_result_after_work, clk, rst_n, $rose(out_valid) |-> $past(!in_ready))
    `PIDC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    `PIDC_ASSERT(a_out_stable, clk, rst_n, (out_valid && !out_ready) |=> ($stable(drive) && $stable(integ_value) && $stable(error_value)))

endmodule

bind position_pid_clamped_integrator pidc_chk u_pidc_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive       (drive),
    .integ_value (integ_value),
    .error_value (error_value)
);

`default_nettype wire
